// ----- sv/hsfc_pkg.sv -----
// ----------------------------------------------------------------------------
// hsfc_pkg
// shared types, constants and the bytewise crc-8 step for the frame checker
// ----------------------------------------------------------------------------
package hsfc_pkg;

  localparam logic [7:0] CRC_POLY_RST = 8'h31;
  localparam logic [7:0] CRC_SEED_RST = 8'hFF;

  localparam logic [1:0] CFG_CRC_POLY = 2'd0;
  localparam logic [1:0] CFG_CRC_SEED = 2'd1;

  localparam logic [2:0] POS_T_HI  = 3'd0;
  localparam logic [2:0] POS_T_LO  = 3'd1;
  localparam logic [2:0] POS_T_CRC = 3'd2;
  localparam logic [2:0] POS_H_HI  = 3'd3;
  localparam logic [2:0] POS_H_LO  = 3'd4;
  localparam logic [2:0] POS_H_CRC = 3'd5;

  typedef struct packed {
    logic        status;
    logic [15:0] temp_word;
    logic [15:0] humi_word;
  } hsfc_raw_t;

  function automatic logic [7:0] crc_byte(input logic [7:0] crc, input logic [7:0] b,
                                          input logic [7:0] poly);
    logic [7:0] c;
    c = crc ^ b;
    for (int k = 0; k < 8; k++) begin
      if (c[7]) begin
        c = {c[6:0], 1'b0} ^ poly;
      end else begin
        c = {c[6:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

// ----- sv/hsfc_frame.sv -----
// ----------------------------------------------------------------------------
// hsfc_frame
// tracks the byte position, runs the crc and collects both raw words
// ----------------------------------------------------------------------------
module hsfc_frame
  import hsfc_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_take,
  input  logic [7:0] rx_byte,
  input  logic       frame_start,
  input  logic [7:0] crc_poly,
  input  logic [7:0] crc_seed,
  output logic       raw_valid,
  output hsfc_raw_t  raw
);

  logic [2:0]  byte_pos_r, byte_pos_nxt;
  logic [7:0]  crc_acc_r, crc_acc_nxt;
  logic [15:0] word_hold_r, word_hold_nxt;
  logic [15:0] temp_hold_r, temp_hold_nxt;
  logic        first_ok_r, first_ok_nxt;
  logic [2:0]  pos;
  logic [7:0]  crc_in;
  logic [7:0]  crc_new;
  logic        last;

  assign pos     = (frame_start || byte_pos_r > POS_H_CRC) ? POS_T_HI : byte_pos_r;
  assign crc_in  = (pos == POS_T_HI || pos == POS_H_HI) ? crc_seed : crc_acc_r;
  assign crc_new = crc_byte(crc_in, rx_byte, crc_poly);

  always_comb begin
    byte_pos_nxt  = byte_pos_r;
    crc_acc_nxt   = crc_acc_r;
    word_hold_nxt = word_hold_r;
    temp_hold_nxt = temp_hold_r;
    first_ok_nxt  = first_ok_r;
    last          = 1'b0;
    case (pos)
      POS_T_HI, POS_H_HI: begin
        crc_acc_nxt   = crc_new;
        word_hold_nxt = {8'h00, rx_byte};
        byte_pos_nxt  = pos + 3'd1;
      end
      POS_T_LO, POS_H_LO: begin
        crc_acc_nxt   = crc_new;
        word_hold_nxt = {word_hold_r[7:0], rx_byte};
        byte_pos_nxt  = pos + 3'd1;
      end
      POS_T_CRC: begin
        first_ok_nxt  = (crc_acc_r == rx_byte);
        temp_hold_nxt = word_hold_r;
        crc_acc_nxt   = crc_seed;
        byte_pos_nxt  = POS_H_HI;
      end
      default: begin
        last         = 1'b1;
        crc_acc_nxt  = crc_seed;
        byte_pos_nxt = POS_T_HI;
      end
    endcase
  end

  assign raw_valid     = in_take && last;
  assign raw.status    = !(first_ok_r && (crc_acc_r == rx_byte));
  assign raw.temp_word = temp_hold_r;
  assign raw.humi_word = word_hold_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_pos_r  <= POS_T_HI;
      crc_acc_r   <= CRC_SEED_RST;
      word_hold_r <= 16'h0000;
      temp_hold_r <= 16'h0000;
      first_ok_r  <= 1'b0;
    end else if (in_take) begin
      byte_pos_r  <= byte_pos_nxt;
      crc_acc_r   <= crc_acc_nxt;
      word_hold_r <= word_hold_nxt;
      temp_hold_r <= temp_hold_nxt;
      first_ok_r  <= first_ok_nxt;
    end
  end

endmodule

// ----- sv/hsfc_conv.sv -----
// ----------------------------------------------------------------------------
// hsfc_conv
// converts the raw words to tenths of a degree and half percent, result register
// ----------------------------------------------------------------------------
module hsfc_conv
  import hsfc_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              raw_valid,
  input  hsfc_raw_t         raw,
  input  logic              out_stall,
  output logic              out_valid,
  output logic              out_status,
  output logic [15:0]       out_temp_word,
  output logic [15:0]       out_humi_word,
  output logic signed [11:0] out_temp_tenths,
  output logic [7:0]        out_humi_halves
);

  localparam logic [26:0]        TEMP_SCALE  = 27'd1750;
  localparam logic signed [27:0] TEMP_OFFSET = 28'sd29491200;
  localparam logic signed [27:0] TRUNC_BIAS  = 28'sd65535;
  localparam logic [23:0]        HUMI_SCALE  = 24'd200;

  logic [26:0]        temp_prod;
  logic signed [27:0] temp_num;
  logic signed [27:0] temp_adj;
  logic signed [27:0] temp_quot;
  logic [23:0]        humi_prod;

  logic        out_valid_r, out_valid_nxt;
  logic        status_r;
  logic [15:0] temp_word_r;
  logic [15:0] humi_word_r;
  logic [11:0] temp_tenths_r;
  logic [7:0]  humi_halves_r;

  assign temp_prod = 27'(raw.temp_word) * TEMP_SCALE;
  assign temp_num  = $signed({1'b0, temp_prod}) - TEMP_OFFSET;
  assign temp_adj  = temp_num[27] ? (temp_num + TRUNC_BIAS) : temp_num;
  assign temp_quot = temp_adj >>> 16;
  assign humi_prod = 24'(raw.humi_word) * HUMI_SCALE;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (raw_valid) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (raw_valid) begin
      status_r      <= raw.status;
      temp_word_r   <= raw.temp_word;
      humi_word_r   <= raw.humi_word;
      temp_tenths_r <= temp_quot[11:0];
      humi_halves_r <= humi_prod[23:16];
    end
  end

  assign out_valid       = out_valid_r;
  assign out_status      = status_r;
  assign out_temp_word   = temp_word_r;
  assign out_humi_word   = humi_word_r;
  assign out_temp_tenths = $signed(temp_tenths_r);
  assign out_humi_halves = humi_halves_r;

endmodule

// ----- sv/humidity_sensor_frame_checker_unit.sv -----
// ----------------------------------------------------------------------------
// humidity_sensor_frame_checker_unit
// checks a six-byte temperature/humidity frame and converts both readings
// ----------------------------------------------------------------------------
// one frame byte per input beat (in_valid / in_stall), in_frame_start marks
// byte 0; bytes are temp hi, temp lo, temp crc, humi hi, humi lo, humi crc.
// one result beat per frame (out_valid / out_stall) carries status, both raw
// words, temperature in tenths of a degree and humidity in half percent.
// a byte is taken every cycle while in_stall is low; the result of the
// sixth byte shows on the output in the cycle after that byte is taken,
// from the result register. the crc is updated a whole byte at a time in a
// combinational step; the conversion is one multiply ahead of the result register.
// in_stall is high only while a result waits and the receiver stalls it.
// configuration beats (cfg_valid / cfg_ready) are always taken: index 0 is
// the crc polynomial, index 1 the crc seed, other indexes are dropped.
// reset clears the frame position, loads 0x31 / 0xff into the registers and
// empties the result register.
// ----------------------------------------------------------------------------
module humidity_sensor_frame_checker_unit
  import hsfc_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [7:0]         in_rx_byte,
  input  logic               in_frame_start,
  output logic               out_valid,
  input  logic               out_stall,
  output logic               out_status,
  output logic [15:0]        out_temp_word,
  output logic [15:0]        out_humi_word,
  output logic signed [11:0] out_temp_tenths,
  output logic [7:0]         out_humi_halves,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [7:0]         cfg_data
);

  logic [7:0] crc_poly_r;
  logic [7:0] crc_seed_r;
  logic       in_take;
  logic       raw_valid;
  hsfc_raw_t  raw;

  assign cfg_ready = 1'b1;
  assign in_stall  = out_valid && out_stall;
  assign in_take   = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      crc_poly_r <= CRC_POLY_RST;
      crc_seed_r <= CRC_SEED_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_CRC_POLY: crc_poly_r <= cfg_data;
        CFG_CRC_SEED: crc_seed_r <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  hsfc_frame u_frame (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_take     (in_take),
    .rx_byte     (in_rx_byte),
    .frame_start (in_frame_start),
    .crc_poly    (crc_poly_r),
    .crc_seed    (crc_seed_r),
    .raw_valid   (raw_valid),
    .raw         (raw)
  );

  hsfc_conv u_conv (
    .clk             (clk),
    .rst_n           (rst_n),
    .raw_valid       (raw_valid),
    .raw             (raw),
    .out_stall       (out_stall),
    .out_valid       (out_valid),
    .out_status      (out_status),
    .out_temp_word   (out_temp_word),
    .out_humi_word   (out_humi_word),
    .out_temp_tenths (out_temp_tenths),
    .out_humi_halves (out_humi_halves)
  );

endmodule

// ----- verif/tb_humidity_sensor_frame_checker_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_humidity_sensor_frame_checker_unit
// self-checking bench for the six-byte humidity sensor frame checker
// ----------------------------------------------------------------------------
// a short table of directed frames (known crc example, extreme words, bad
// checksums, missing and mid-frame start flags) runs first, then several
// phases of random frames under different crc polynomial / seed settings.
// every accepted byte goes through an in-bench frame model that predicts the
// result beat; result beats are checked field by field in order. the sender
// idles in random bursts, the receiver stalls on its own pattern and once
// holds off long enough to back the block up.
// ----------------------------------------------------------------------------
module tb_humidity_sensor_frame_checker_unit;
  import hsfc_pkg::*;

  localparam int CLK_PERIOD       = 20;
  localparam int RESET_CYCLES     = 7;
  localparam int CYCLE_LIMIT      = 400000;
  localparam int SETTLE_CYCLES    = 4;
  localparam int TAIL_CYCLES      = 10;
  localparam int LONG_HOLD_CYCLES = 300;
  localparam int NUM_PHASES       = 6;
  localparam int ITEMS_PER_PHASE  = 321;
  localparam int NUM_DIRECTED     = 25;

  localparam logic [1:0] REG_SPARE_2 = 2'd2;
  localparam logic [1:0] REG_SPARE_3 = 2'd3;

  localparam longint     TEMP_GAIN   = 1750;
  localparam longint     TEMP_OFFSET = 29491200;
  localparam longint     TEMP_DIV    = 65536;
  localparam logic [31:0] HUMI_GAIN  = 32'd200;

  typedef enum logic [1:0] {BYTE_RAW, BYTE_CRC_GOOD, BYTE_CRC_BAD} byte_kind_t;
  typedef enum logic [1:0] {RX_FLOW, RX_LIGHT, RX_HEAVY, RX_PERIODIC} stall_mode_t;

  typedef struct packed {
    logic               status;
    logic [15:0]        temp_word;
    logic [15:0]        humi_word;
    logic signed [11:0] temp_tenths;
    logic [7:0]         humi_halves;
  } frame_result_t;

  typedef struct packed {
    logic [7:0]    data;
    logic          start;
    byte_kind_t    kind;
    logic          typed;
    frame_result_t want;
  } stim_row_t;

  localparam frame_result_t NO_RESULT = '0;

  logic               clk             = 1'b0;
  logic               rst_n           = 1'b0;
  logic               in_valid        = 1'b0;
  logic               in_stall;
  logic [7:0]         in_rx_byte      = 8'h00;
  logic               in_frame_start  = 1'b0;
  logic               out_valid;
  logic               out_stall       = 1'b0;
  logic               out_status;
  logic [15:0]        out_temp_word;
  logic [15:0]        out_humi_word;
  logic signed [11:0] out_temp_tenths;
  logic [7:0]         out_humi_halves;
  logic               cfg_valid       = 1'b0;
  logic               cfg_ready;
  logic [1:0]         cfg_index       = 2'd0;
  logic [7:0]         cfg_data        = 8'h00;

  humidity_sensor_frame_checker_unit DUT (.*);

  always #(CLK_PERIOD / 2) clk = ~clk;

  // frame model state
  logic [7:0]  poly_q;
  logic [7:0]  seed_q;
  logic [2:0]  pos_q;
  logic [7:0]  crc_run;
  logic [15:0] word_acc;
  logic [15:0] temp_keep;
  logic        temp_crc_ok;

  frame_result_t frame_results_q[$];

  int  mismatches    = 0;
  int  results_seen  = 0;
  int  crc_err_seen  = 0;
  int  bytes_sent    = 0;
  int  reg_writes    = 0;
  int  burst_left    = 0;
  int  cycles        = 0;
  bit  sender_steady = 1'b0;
  bit  hold_req      = 1'b0;

  stim_row_t directed_rows [NUM_DIRECTED] = '{
    '{8'hBE, 1'b1, BYTE_RAW,      1'b0, NO_RESULT},
    '{8'hEF, 1'b0, BYTE_RAW,      1'b0, NO_RESULT},
    '{8'h92, 1'b0, BYTE_RAW,      1'b0, NO_RESULT},
    '{8'hBE, 1'b0, BYTE_RAW,      1'b0, NO_RESULT},
    '{8'hEF, 1'b0, BYTE_RAW,      1'b0, NO_RESULT},
    '{8'h92, 1'b0, BYTE_RAW,      1'b1,
      '{1'b0, 16'hBEEF, 16'hBEEF, 12'sd855, 8'd149}},
    '{8'h00, 1'b1, BYTE_RAW,      1'b0, NO_RESULT},
    '{8'h00, 1'b0, BYTE_RAW,      1'b0, NO_RESULT},
    '{8'h00, 1'b0, BYTE_CRC_BAD,  1'b0, NO_RESULT},
    '{8'hFF, 1'b0, BYTE_RAW,      1'b0, NO_RESULT},
    '{8'hFF, 1'b0, BYTE_RAW,      1'b0, NO_RESULT},
    '{8'h00, 1'b0, BYTE_CRC_GOOD, 1'b1,
      '{1'b1, 16'h0000, 16'hFFFF, -12'sd450, 8'd199}},
    '{8'hFF, 1'b0, BYTE_RAW,      1'b0, NO_RESULT},
    '{8'hFF, 1'b0, BYTE_RAW,      1'b0, NO_RESULT},
    '{8'h00, 1'b0, BYTE_CRC_GOOD, 1'b0, NO_RESULT},
    '{8'h00, 1'b0, BYTE_RAW,      1'b0, NO_RESULT},
    '{8'h00, 1'b0, BYTE_RAW,      1'b0, NO_RESULT},
    '{8'h00, 1'b0, BYTE_CRC_BAD,  1'b1,
      '{1'b1, 16'hFFFF, 16'h0000, 12'sd1299, 8'd0}},
    '{8'h12, 1'b1, BYTE_RAW,      1'b0, NO_RESULT},
    '{8'h56, 1'b1, BYTE_RAW,      1'b0, NO_RESULT},
    '{8'h78, 1'b0, BYTE_RAW,      1'b0, NO_RESULT},
    '{8'h00, 1'b0, BYTE_CRC_GOOD, 1'b0, NO_RESULT},
    '{8'h9A, 1'b0, BYTE_RAW,      1'b0, NO_RESULT},
    '{8'hBC, 1'b0, BYTE_RAW,      1'b0, NO_RESULT},
    '{8'h00, 1'b0, BYTE_CRC_GOOD, 1'b0, NO_RESULT}
  };

  // bit-serial crc-8, msb first
  function automatic logic [7:0] crc8_update(input logic [7:0] acc, input logic [7:0] data,
                                             input logic [7:0] poly);
    logic [7:0] r;
    logic       fb;
    int         i;
    r = acc;
    for (i = 7; i >= 0; i--) begin
      fb = r[7] ^ data[i];
      r  = {r[6:0], 1'b0};
      if (fb) begin
        r = r ^ poly;
      end
    end
    return r;
  endfunction

  function automatic void frame_step(input logic [7:0] b, input logic start,
                                     output bit done, output frame_result_t res);
    logic [2:0]  pos;
    longint      raw_t;
    longint      tenths;
    logic [31:0] humi_prod;
    done = 1'b0;
    res  = NO_RESULT;
    pos  = (start || pos_q > POS_H_CRC) ? POS_T_HI : pos_q;
    case (pos)
      POS_T_HI, POS_H_HI: begin
        crc_run  = crc8_update(seed_q, b, poly_q);
        word_acc = {8'h00, b};
        pos_q    = pos + 3'd1;
      end
      POS_T_LO, POS_H_LO: begin
        crc_run  = crc8_update(crc_run, b, poly_q);
        word_acc = {word_acc[7:0], b};
        pos_q    = pos + 3'd1;
      end
      POS_T_CRC: begin
        temp_crc_ok = (crc_run == b);
        temp_keep   = word_acc;
        crc_run     = seed_q;
        pos_q       = POS_H_HI;
      end
      default: begin
        raw_t           = temp_keep;
        tenths          = (TEMP_GAIN * raw_t - TEMP_OFFSET) / TEMP_DIV;
        humi_prod       = HUMI_GAIN * {16'd0, word_acc};
        res.status      = !(temp_crc_ok && crc_run == b);
        res.temp_word   = temp_keep;
        res.humi_word   = word_acc;
        res.temp_tenths = tenths[11:0];
        res.humi_halves = humi_prod[23:16];
        crc_run         = seed_q;
        pos_q           = POS_T_HI;
        done            = 1'b1;
      end
    endcase
  endfunction

  task automatic report_mismatch(input string field, input longint got, input longint want);
    $display("mismatch on %s at result %0d: got %0d, expected %0d",
             field, results_seen, got, want);
    mismatches++;
  endtask

  task automatic send_byte(input logic [7:0] data, input logic start, input byte_kind_t kind,
                           input logic typed, input frame_result_t want);
    logic [7:0]    b;
    bit            done;
    frame_result_t pred;
    int            gap;
    if (!sender_steady && burst_left == 0) begin
      gap        = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 6);
      burst_left = $urandom_range(1, 30);
      in_valid  <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    if (burst_left > 0) begin
      burst_left--;
    end
    case (kind)
      BYTE_CRC_GOOD: b = crc_run;
      BYTE_CRC_BAD:  b = crc_run ^ 8'($urandom_range(1, 255));
      default:       b = data;
    endcase
    in_valid       <= 1'b1;
    in_rx_byte     <= b;
    in_frame_start <= start;
    do @(posedge clk); while (in_stall);
    frame_step(b, start, done, pred);
    if (done) begin
      frame_results_q.push_back(typed ? want : pred);
    end
    bytes_sent++;
  endtask

  function automatic logic [7:0] pick_data();
    case ($urandom_range(0, 7))
      0:       return 8'h00;
      1:       return 8'hFF;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  task automatic send_random_frame();
    int         r;
    int         n;
    int         i;
    logic       start0;
    byte_kind_t kind;
    r = $urandom_range(0, 99);
    if (r < 72) begin
      start0 = ($urandom_range(0, 4) != 0);
      for (i = 0; i < 6; i++) begin
        if (i == 2 || i == 5) begin
          kind = ($urandom_range(0, 9) == 0) ? BYTE_CRC_BAD : BYTE_CRC_GOOD;
        end else begin
          kind = BYTE_RAW;
        end
        send_byte(pick_data(), (i == 0) ? start0 : 1'b0, kind, 1'b0, NO_RESULT);
      end
    end else if (r < 86) begin
      // frame cut short, the next start flag drops it
      n = $urandom_range(1, 5);
      for (i = 0; i < n; i++) begin
        send_byte(pick_data(), i == 0, (i == 2) ? BYTE_CRC_GOOD : BYTE_RAW, 1'b0, NO_RESULT);
      end
    end else begin
      n = $urandom_range(1, 8);
      for (i = 0; i < n; i++) begin
        send_byte(8'($urandom_range(0, 255)), $urandom_range(0, 3) == 0, BYTE_RAW,
                  1'b0, NO_RESULT);
      end
    end
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [7:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_CRC_POLY: poly_q = val;
      CFG_CRC_SEED: seed_q = val;
      default: ;
    endcase
    reg_writes++;
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    while (frame_results_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // result checker
  always @(posedge clk) begin : check_results
    frame_result_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (frame_results_q.size() == 0) begin
        report_mismatch("unexpected result beat", 1, 0);
      end else begin
        want = frame_results_q.pop_front();
        if (out_status !== want.status)
          report_mismatch("status", out_status, want.status);
        if (out_temp_word !== want.temp_word)
          report_mismatch("temp_word", out_temp_word, want.temp_word);
        if (out_humi_word !== want.humi_word)
          report_mismatch("humi_word", out_humi_word, want.humi_word);
        if (out_temp_tenths !== want.temp_tenths)
          report_mismatch("temp_tenths", out_temp_tenths, want.temp_tenths);
        if (out_humi_halves !== want.humi_halves)
          report_mismatch("humi_halves", out_humi_halves, want.humi_halves);
        results_seen++;
        if (want.status) begin
          crc_err_seen++;
        end
      end
    end
  end

  // receiver stall pattern
  initial begin : stall_pattern
    stall_mode_t mode;
    int          mode_left;
    int          held;
    mode      = RX_FLOW;
    mode_left = 0;
    @(posedge rst_n);
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        out_stall <= 1'b1;
        for (held = 1; held < LONG_HOLD_CYCLES; held++) @(posedge clk);
      end else begin
        if (mode_left == 0) begin
          mode      = stall_mode_t'($urandom_range(0, 3));
          mode_left = $urandom_range(20, 200);
        end
        mode_left--;
        case (mode)
          RX_FLOW:  out_stall <= 1'b0;
          RX_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
          RX_HEAVY: out_stall <= ($urandom_range(0, 9) < 7);
          default:  out_stall <= (mode_left % 3 == 0);
        endcase
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding",
               cycles, frame_results_q.size());
      $display("Regression FAIL");
      $finish;
    end
  end

  initial begin : main_seq
    logic [7:0] poly_plan [NUM_PHASES];
    logic [7:0] seed_plan [NUM_PHASES];
    int         p;
    int         k;
    int         phase_end;
    poly_q      = CRC_POLY_RST;
    seed_q      = CRC_SEED_RST;
    pos_q       = POS_T_HI;
    crc_run     = CRC_SEED_RST;
    word_acc    = 16'h0000;
    temp_keep   = 16'h0000;
    temp_crc_ok = 1'b0;
    poly_plan   = '{8'h00, 8'hFF, 8'h07, 8'($urandom_range(1, 254)), 8'h31,
                    8'($urandom_range(0, 255))};
    seed_plan   = '{8'h00, 8'hFF, 8'h00, 8'($urandom_range(1, 254)), 8'hFF,
                    8'($urandom_range(0, 255))};

    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (k = 0; k < NUM_DIRECTED; k++) begin
      send_byte(directed_rows[k].data, directed_rows[k].start, directed_rows[k].kind,
                directed_rows[k].typed, directed_rows[k].want);
    end

    for (p = 0; p < NUM_PHASES; p++) begin
      settle();
      write_reg(CFG_CRC_POLY, poly_plan[p]);
      write_reg((p % 2 == 1) ? REG_SPARE_3 : REG_SPARE_2, 8'($urandom_range(0, 255)));
      write_reg(CFG_CRC_SEED, seed_plan[p]);
      cfg_valid <= 1'b0;
      sender_steady = (p % 2 == 1);
      if (p == 1) begin
        hold_req = 1'b1;
      end
      phase_end = bytes_sent + ITEMS_PER_PHASE;
      while (bytes_sent < phase_end) send_random_frame();
    end

    in_valid <= 1'b0;
    while (frame_results_q.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("sent %0d frame bytes, checked %0d frame results, %0d of them with bad checksums",
             bytes_sent, results_seen, crc_err_seen);
    $display("%0d register writes over %0d crc settings, incl. spare indexes and a long hold",
             reg_writes, NUM_PHASES + 1);
    if (mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
